@@ sv/alb_pkg.sv @@
package alb_pkg;

  localparam int LINES      = 192;
  localparam int LINE_WIDTH = 256;
  localparam int CODE_BYTES = (LINES + 3) / 4;
  localparam int CODE_DEPTH = 2 * CODE_BYTES;
  localparam int CODE_AW    = (CODE_DEPTH > 2) ? $clog2(CODE_DEPTH) : 1;
  localparam int CHUNKS     = LINE_WIDTH / 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] CHUNK_MASK = 32'hFFFF_FFFF << (32 - CHUNKS);
  localparam logic [31:0] FIRST_FLAG = 32'h8000_0000;

  localparam logic [1:0] CODE_EMPTY = 2'd0;
  localparam logic [1:0] CODE_RAW   = 2'd3;

  // One stream byte, tagged by the front end.
  typedef struct packed {
    logic               is_code;
    logic               last;
    logic [CODE_AW-1:0] addr;
    logic [7:0]         data;
  } item_t;

  typedef struct packed {
    logic       has_pixels;
    logic       layer_index;
    logic [7:0] line_index;
    logic [4:0] chunk_index;
    logic [7:0] pixel_bits;
    logic       frame_done;
  } result_t;

  typedef enum logic [2:0] {
    ST_CODES,
    ST_FLAGS,
    ST_CHUNKS,
    ST_SEEK_RD,
    ST_SEEK_EV,
    ST_DONE
  } back_state_e;

endpackage

@@ sv/alb_in_if.sv @@
interface alb_in_if;
  import alb_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ sv/alb_out_if.sv @@
interface alb_out_if;
  import alb_pkg::*;

  logic       valid;
  logic       ready;
  logic       has_pixels;
  logic       layer_index;
  logic [7:0] line_index;
  logic [4:0] chunk_index;
  logic [7:0] pixel_bits;
  logic       frame_done;

  modport source (
    output valid, output has_pixels, output layer_index, output line_index,
    output chunk_index, output pixel_bits, output frame_done, input ready
  );
  modport sink (
    input valid, input has_pixels, input layer_index, input line_index,
    input chunk_index, input pixel_bits, input frame_done, output ready
  );
endinterface

@@ sv/alb_ram.sv @@
module alb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ sv/alb_queue.sv @@
module alb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  alb_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output alb_pkg::item_t pop_item_o
);
  import alb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

  item_t           slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o      = cnt_q == (PW + 1)'(QUEUE_DEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign pop_item_o  = slot_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end
endmodule

@@ sv/alb_front.sv @@
module alb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  alb_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output alb_pkg::item_t push_item_o
);
  import alb_pkg::*;

  logic [CODE_AW-1:0] cnt_q, cnt_d;
  logic               codes_done_q, codes_done_d;
  logic               last_code;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign last_code  = cnt_q == CODE_AW'(CODE_DEPTH - 1);

  // The first bytes of the stream are the line-type table; tag them with
  // their table address so the back end only has to store them.
  always_comb begin
    push_item_o.is_code = !codes_done_q;
    push_item_o.last    = !codes_done_q && last_code;
    push_item_o.addr    = cnt_q;
    push_item_o.data    = in_i.byte_in;
  end

  always_comb begin
    cnt_d        = cnt_q;
    codes_done_d = codes_done_q;
    if (push_o && !codes_done_q) begin
      if (last_code) begin
        codes_done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CODE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      codes_done_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      codes_done_q <= codes_done_d;
    end
  end
endmodule

@@ sv/alb_back.sv @@
module alb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  alb_pkg::item_t pop_item_i,
  output logic           pop_o,
  alb_out_if.source      out_o
);
  import alb_pkg::*;

  back_state_e        state_q, state_d;
  logic               layer_q, layer_d;
  logic [7:0]         line_q, line_d;
  logic [31:0]        flags_q, flags_d;
  logic [1:0]         byte_cnt_q, byte_cnt_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic               take;
  logic               busy;
  logic [CODE_AW-1:0] raddr;
  logic [7:0]         rdata;
  logic [1:0]         code;
  logic [31:0]        flags_word;
  logic [31:0]        flags_left;
  logic [4:0]         pos;
  logic               flag_last;
  logic               line_last;
  logic               adv_end;
  logic               advance;

  function automatic logic [4:0] first_flag(input logic [31:0] f);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (f[i]) begin
        p = 5'(31 - i);
      end
    end
    return p;
  endfunction

  assign busy  = state_q == ST_SEEK_RD || state_q == ST_SEEK_EV;
  assign take  = pop_valid_i && !busy && (!out_valid_q || out_o.ready);
  assign pop_o = take;

  assign raddr = layer_q ? CODE_AW'(CODE_BYTES) + CODE_AW'(line_q[7:2])
                         : CODE_AW'(line_q[7:2]);

  alb_ram #(
    .WIDTH (8),
    .DEPTH (CODE_DEPTH)
  ) u_codes (
    .clk_i   (clk_i),
    .we_i    (take && pop_item_i.is_code),
    .waddr_i (pop_item_i.addr),
    .wdata_i (pop_item_i.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign code       = rdata[{line_q[1:0], 1'b0} +: 2];
  assign flags_word = {flags_q[23:0], pop_item_i.data} & CHUNK_MASK;
  // Sent chunks are cleared from the flag word; the next chunk is the
  // highest flag still set.
  assign pos        = first_flag(flags_q);
  assign flags_left = flags_q & ~(FIRST_FLAG >> pos);
  assign flag_last  = byte_cnt_q == 2'd3;
  assign line_last  = line_q == 8'(LINES - 1);
  assign adv_end    = line_last && layer_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CODES: begin
        if (take && pop_item_i.last) begin
          state_d = ST_SEEK_RD;
        end
      end
      ST_FLAGS: begin
        if (take && flag_last) begin
          if (flags_word == '0) begin
            state_d = adv_end ? ST_DONE : ST_SEEK_RD;
          end else begin
            state_d = ST_CHUNKS;
          end
        end
      end
      ST_CHUNKS: begin
        if (take && flags_left == '0) begin
          state_d = adv_end ? ST_DONE : ST_SEEK_RD;
        end
      end
      ST_SEEK_RD: state_d = ST_SEEK_EV;
      ST_SEEK_EV: begin
        if (code == CODE_RAW) begin
          state_d = ST_CHUNKS;
        end else if (code == CODE_EMPTY) begin
          state_d = adv_end ? ST_DONE : ST_SEEK_RD;
        end else begin
          state_d = ST_FLAGS;
        end
      end
      ST_DONE: state_d = ST_DONE;
      default: state_d = ST_CODES;
    endcase
  end

  assign advance = (state_d == ST_SEEK_RD || state_d == ST_DONE) &&
                   ((take && (state_q == ST_FLAGS || state_q == ST_CHUNKS)) ||
                    state_q == ST_SEEK_EV);

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    flags_d     = flags_q;
    byte_cnt_d  = byte_cnt_q;
    layer_d     = layer_q;
    line_d      = line_q;

    if (take) begin
      res_d       = '0;
      out_valid_d = 1'b1;
      case (state_q)
        ST_FLAGS: begin
          flags_d    = {flags_q[23:0], pop_item_i.data};
          byte_cnt_d = byte_cnt_q + 2'd1;
          if (flag_last) begin
            flags_d    = flags_word;
            byte_cnt_d = '0;
          end
        end
        ST_CHUNKS: begin
          res_d.has_pixels  = 1'b1;
          res_d.layer_index = layer_q;
          res_d.line_index  = line_q;
          res_d.chunk_index = pos;
          res_d.pixel_bits  = pop_item_i.data;
          flags_d           = flags_left;
        end
        default: ;
      endcase
      res_d.frame_done = state_d == ST_DONE;
    end

    if (state_q == ST_SEEK_EV) begin
      out_valid_d      = state_d != ST_SEEK_RD;
      res_d.frame_done = state_d == ST_DONE;
      if (state_d == ST_CHUNKS) begin
        flags_d = CHUNK_MASK;
      end else if (state_d == ST_FLAGS) begin
        flags_d    = '0;
        byte_cnt_d = '0;
      end
    end

    // A result whose frame_done depends on the line search is held back
    // until the search ends.
    if (state_d == ST_SEEK_RD) begin
      out_valid_d = 1'b0;
    end

    if (advance) begin
      line_d  = line_last ? '0 : line_q + 8'd1;
      layer_d = line_last ? !layer_q : layer_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CODES;
      layer_q     <= 1'b0;
      line_q      <= '0;
      flags_q     <= '0;
      byte_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      layer_q     <= layer_d;
      line_q      <= line_d;
      flags_q     <= flags_d;
      byte_cnt_q  <= byte_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.has_pixels  = res_q.has_pixels;
  assign out_o.layer_index = res_q.layer_index;
  assign out_o.line_index  = res_q.line_index;
  assign out_o.chunk_index = res_q.chunk_index;
  assign out_o.pixel_bits  = res_q.pixel_bits;
  assign out_o.frame_done  = res_q.frame_done;
endmodule

@@ sv/animation_layer_bitmap_decoder.sv @@
// Channel   Dir   Contents                                          Transfer
// in_i      in    byte_in: next byte of the layer stream            valid & ready
// out_o     out   has_pixels, layer_index, line_index, chunk_index,  valid & ready
//                 pixel_bits, frame_done (one result per byte)
//
// A byte that stays within a line passes through the two-entry queue and
// then the back end's result register. Ending the table or a line starts a
// search of the line-type table in its RAM, which examines each line in a
// read step and then an evaluate step, skips empty lines and ends at the
// next coded line or at the end of the frame.
// Reset needs no clearing pass; the table is always written before it is read.
// The front end takes bytes into the queue while the back end is stalled, until the queue is full.
module animation_layer_bitmap_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  alb_in_if.sink     in_i,
  alb_out_if.source  out_o
);
  import alb_pkg::*;

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;

  alb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  alb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item)
  );

  alb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );
endmodule
